### rtl/assert_macros.svh
// Assertion macros shared by the RTL; they assume a clock clk and an active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cossim_pkg.sv
// Types and fixed constants of the cosine similarity core.
package cossim_pkg;

  localparam int ELEM_W     = 16;              // element width, Q1.15
  localparam int SIM_W      = 16;              // result width, Q1.15
  localparam int ROOT_BITS  = 16;              // bits of the quotient search
  localparam int ROOT_SHIFT = 2 * (ROOT_BITS - 1);

  localparam logic [ROOT_BITS-1:0] POS_LIMIT = 16'h7FFF;  // +0.99997
  localparam logic [ROOT_BITS-1:0] NEG_LIMIT = 16'h8000;  // magnitude of -1.0

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
  } out_item_t;

endpackage

### rtl/cosine_similarity_core.sv
// Cosine similarity core: streamed dot product and norms, then an iterative root/divide.
//
// Element pairs (a, b) arrive as signed Q1.15, one per item. Ordinary items are
// taken every cycle and fold a*b, a*a and b*b into three ACC_WIDTH-bit
// accumulators that wrap on overflow. The item marked last is folded in too,
// then the core stalls its input while one shared (2*ACC_WIDTH+32)-bit adder,
// stepped by a small sequencer, forms na*nb and dot^2 by shift-and-add
// and then searches the 16-bit quotient q with q^2*na*nb <= 2^30*dot^2,
// one bit per trial step. The result is dot/sqrt(na*nb) in Q1.15,
// truncated toward zero and saturated to [-32768, 32767]; a zero norm gives
// 0 with zero_norm set. Accumulators clear in the norm check, before the
// result is formed. The result sits in an output register, so the next
// vector may stream in while it waits to be taken.
`include "assert_macros.svh"

module cosine_similarity_core
  import cossim_pkg::*;
#(
  parameter int ACC_WIDTH = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int W     = 2 * ACC_WIDTH + 2 * ROOT_BITS;  // root datapath width
  localparam int CNT_W = $clog2(ACC_WIDTH);
  localparam int PROD_W = 2 * ELEM_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_MULP   = 3'd2;
  localparam logic [2:0] ST_MULR   = 3'd3;
  localparam logic [2:0] ST_TRIPLE = 3'd4;
  localparam logic [2:0] ST_TRIAL  = 3'd5;
  localparam logic [2:0] ST_UPDATE = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [ACC_WIDTH-1:0] dot_acc_r, dot_acc_nxt;
  logic [ACC_WIDTH-1:0] norm_a_acc_r, norm_a_acc_nxt;
  logic [ACC_WIDTH-1:0] norm_b_acc_r, norm_b_acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // root datapath
  logic [ACC_WIDTH-1:0] x_r, x_nxt;        // multiplicand
  logic [ACC_WIDTH-1:0] y_r, y_nxt;        // multiplier, MSB first
  logic [ACC_WIDTH-1:0] mag_r, mag_nxt;    // |dot|
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;
  logic [W-1:0]         work_r, work_nxt;  // shift-add partial product
  logic [W-1:0]         d_r, d_nxt;        // 2^30*dot^2 less accepted lhs
  logic [W-1:0]         u_r, u_nxt;        // lhs increment for the trial bit
  logic [W-1:0]         p4_r, p4_nxt;      // (P << 2k) / 4
  logic [W-1:0]         p34_r, p34_nxt;    // 3 * (P << 2k) / 4
  logic [ROOT_BITS-1:0] q_r, q_nxt;
  logic                 take_r, take_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // shared adder
  logic [W-1:0] add_a, add_b;
  logic         add_cin;
  logic [W-1:0] add_sum;
  logic         add_co;

  // element products
  logic signed [PROD_W-1:0] prod_ab, prod_aa, prod_bb;
  logic [ACC_WIDTH-1:0]     ext_ab, ext_aa, ext_bb;

  logic [ROOT_BITS-1:0] q_sat;
  logic [SIM_W-1:0]     sim_val;

  assign prod_ab = in_data.a_elem * in_data.b_elem;
  assign prod_aa = in_data.a_elem * in_data.a_elem;
  assign prod_bb = in_data.b_elem * in_data.b_elem;
  assign ext_ab  = ACC_WIDTH'(prod_ab);
  assign ext_aa  = ACC_WIDTH'(prod_aa);
  assign ext_bb  = ACC_WIDTH'(prod_bb);

  assign {add_co, add_sum} = {1'b0, add_a} + {1'b0, add_b} + (W + 1)'(add_cin);

  // saturate and apply the sign
  always_comb begin
    q_sat   = q_r;
    sim_val = '0;
    if (neg_r) begin
      if (q_r > NEG_LIMIT) q_sat = NEG_LIMIT;
      sim_val = SIM_W'(ROOT_BITS'(0) - q_sat);
    end else begin
      if (q_r > POS_LIMIT) q_sat = POS_LIMIT;
      sim_val = SIM_W'(q_sat);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    dot_acc_nxt    = dot_acc_r;
    norm_a_acc_nxt = norm_a_acc_r;
    norm_b_acc_nxt = norm_b_acc_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    zero_nxt       = zero_r;
    work_nxt       = work_r;
    d_nxt          = d_r;
    u_nxt          = u_r;
    p4_nxt         = p4_r;
    p34_nxt        = p34_r;
    q_nxt          = q_r;
    take_nxt       = take_r;
    cnt_nxt        = cnt_r;
    add_a          = '0;
    add_b          = '0;
    add_cin        = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dot_acc_nxt    = dot_acc_r + ext_ab;
          norm_a_acc_nxt = norm_a_acc_r + ext_aa;
          norm_b_acc_nxt = norm_b_acc_r + ext_bb;
          if (in_data.last_elem) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        neg_nxt        = dot_acc_r[ACC_WIDTH-1];
        mag_nxt        = dot_acc_r[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - dot_acc_r) : dot_acc_r;
        dot_acc_nxt    = '0;
        norm_a_acc_nxt = '0;
        norm_b_acc_nxt = '0;
        q_nxt          = '0;
        x_nxt          = norm_a_acc_r;
        y_nxt          = norm_b_acc_r;
        work_nxt       = '0;
        cnt_nxt        = '0;
        if (norm_a_acc_r == '0 || norm_b_acc_r == '0) begin
          zero_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          zero_nxt  = 1'b0;
          state_nxt = ST_MULP;
        end
      end
      ST_MULP, ST_MULR: begin
        add_a    = work_r << 1;
        add_b    = y_r[ACC_WIDTH-1] ? W'(x_r) : '0;
        work_nxt = add_sum;
        y_nxt    = y_r << 1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACC_WIDTH - 1)) begin
          work_nxt = '0;
          cnt_nxt  = '0;
          if (state_r == ST_MULP) begin
            // P = na*nb; first trial increment is P << 30
            u_nxt     = add_sum << ROOT_SHIFT;
            p4_nxt    = add_sum << (ROOT_SHIFT - 2);
            x_nxt     = mag_r;
            y_nxt     = mag_r;
            state_nxt = ST_MULR;
          end else begin
            d_nxt     = add_sum << ROOT_SHIFT;
            state_nxt = ST_TRIPLE;
          end
        end
      end
      ST_TRIPLE: begin
        add_a     = p4_r;
        add_b     = p4_r << 1;
        p34_nxt   = add_sum;
        cnt_nxt   = CNT_W'(ROOT_BITS - 1);
        state_nxt = ST_TRIAL;
      end
      ST_TRIAL: begin
        // d - u, carry out means the trial bit fits
        add_a    = d_r;
        add_b    = ~u_r;
        add_cin  = 1'b1;
        take_nxt = add_co;
        if (add_co) d_nxt = add_sum;
        q_nxt = {q_r[ROOT_BITS-2:0], add_co};
        state_nxt = (cnt_r == '0) ? ST_FINISH : ST_UPDATE;
      end
      ST_UPDATE: begin
        // u' = u/2 + 3Ps/4 after a taken bit, u/2 - Ps/4 otherwise
        add_a     = u_r >> 1;
        add_b     = take_r ? p34_r : ~p4_r;
        add_cin   = ~take_r;
        u_nxt     = add_sum;
        p4_nxt    = p4_r >> 2;
        p34_nxt   = p34_r >> 2;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = ST_TRIAL;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.similarity = zero_r ? '0 : sim_val;
          out_data_nxt.zero_norm  = zero_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dot_acc_r    <= '0;
      norm_a_acc_r <= '0;
      norm_b_acc_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dot_acc_r    <= dot_acc_nxt;
      norm_a_acc_r <= norm_a_acc_nxt;
      norm_b_acc_r <= norm_b_acc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    work_r     <= work_nxt;
    d_r        <= d_nxt;
    u_r        <= u_nxt;
    p4_r       <= p4_nxt;
    p34_r      <= p34_nxt;
    q_r        <= q_nxt;
    take_r     <= take_nxt;
    cnt_r      <= cnt_nxt;
  end

  // a last item always hands over to the norm check
  `ASSERT_NEXT(a_last_starts_check, in_valid && !in_stall && in_data.last_elem, state_r == ST_CHECK, "last item did not start the result sequence")
  // a result only appears from the finish step
  `ASSERT_NEXT(a_valid_from_finish, !out_valid_r && state_r != ST_FINISH, !out_valid_r, "result raised outside the finish step")
  // accumulators are empty once a vector has been closed
  `ASSERT_NEXT(a_acc_cleared, state_r == ST_CHECK, dot_acc_r == '0 && norm_a_acc_r == '0 && norm_b_acc_r == '0, "accumulators not cleared after last item")
  // a zero norm result carries zero similarity
  `ASSERT_NOW(a_zero_norm_value, out_valid_r && out_data_r.zero_norm, out_data_r.similarity == '0, "zero norm result with non-zero similarity")

endmodule
